// ----- src/pls_pkg.sv -----
// Package for the positional list store: beat payload types, codes and
// the command and status types shared by the controller and the datapath.
// No dependencies.
package pls_pkg;

  // Field widths of the beats.
  localparam int unsigned PosW     = 8;
  localparam int unsigned ValW     = 32;
  localparam int unsigned CntOutW  = 5;
  // Largest number of result beats that one list request streams.
  localparam int unsigned MaxResults = 16;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_APPEND = 2'd1,
    REQ_DELETE = 2'd2,
    REQ_LIST   = 2'd3
  } pls_req_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } pls_status_e;

  typedef struct packed {
    pls_req_e               req_type;
    logic signed [ValW-1:0] value_in;
    logic [PosW-1:0]        position;
  } pls_in_t;

  typedef struct packed {
    pls_status_e            status;
    logic signed [ValW-1:0] value_out;
    logic [CntOutW-1:0]     entry_count;
    logic                   last;
  } pls_out_t;

  // Commands from the controller to the datapath.
  typedef enum logic [1:0] {
    OP_NONE    = 2'd0,
    OP_CAPTURE = 2'd1,
    OP_EXEC    = 2'd2,
    OP_ROTATE  = 2'd3
  } pls_op_e;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic list_multi;  // list request on a non-empty list
    logic emit;        // this rotation beat produces a result
    logic rot_done;    // this rotation beat is the final one
  } pls_stat_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EXEC = 2'd1,
    S_LIST = 2'd2
  } pls_state_e;

endpackage

// ----- src/pls_dpath.sv -----
// Datapath of the positional list store: the row of entry cells, the entry
// count, the captured request, the list index and the result register.
// Depends on pls_pkg.
module pls_dpath
  import pls_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  pls_op_e   op_i,
  input  pls_in_t   in_data_i,
  output pls_stat_t stat_o,
  output pls_out_t  out_data_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned IdxW = $clog2(CAPACITY);

  logic [ValW-1:0] cell_q [CAPACITY];
  logic [ValW-1:0] cell_d [CAPACITY];
  pls_in_t         req_q;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] idx_q, idx_d;
  pls_out_t        out_q, out_d;

  logic [PosW-1:0] count_w, pos_w, ins_pos_w, idx_w, n_w, tail_w;
  logic [IdxW-1:0] pos_idx;
  logic            do_ins, do_del, full, emit, last_beat;
  pls_status_e     exec_status;
  logic [ValW-1:0] removed;

  // Compare everything at the position width.
  assign count_w   = PosW'(count_q);
  assign pos_w     = req_q.position;
  assign idx_w     = PosW'(idx_q);
  assign tail_w    = count_w - PosW'(1);
  assign pos_idx   = req_q.position[IdxW-1:0];
  assign full      = (count_q == CntW'(CAPACITY));
  assign n_w       = (count_w < PosW'(MaxResults)) ? count_w : PosW'(MaxResults);
  assign emit      = (idx_w < PosW'(MaxResults));
  assign last_beat = ((idx_w + PosW'(1)) == n_w);
  assign removed   = cell_q[pos_idx];

  // Decide the outcome of a single-result request.
  always_comb begin
    do_ins      = 1'b0;
    do_del      = 1'b0;
    exec_status = ST_OK;
    ins_pos_w   = pos_w;
    case (req_q.req_type)
      REQ_INSERT: begin
        if (pos_w > count_w) begin
          exec_status = ST_RANGE;
        end else if (full) begin
          exec_status = ST_FULL;
        end else begin
          do_ins = 1'b1;
        end
      end
      REQ_APPEND: begin
        ins_pos_w = count_w;
        if (full) begin
          exec_status = ST_FULL;
        end else begin
          do_ins = 1'b1;
        end
      end
      REQ_DELETE: begin
        if (count_q == '0) begin
          exec_status = ST_EMPTY;
        end else if (pos_w >= count_w) begin
          exec_status = ST_RANGE;
        end else begin
          do_del = 1'b1;
        end
      end
      default: begin
        exec_status = ST_OK;
      end
    endcase
  end

  // Cell moves: shift toward the tail on insert, toward the head on delete,
  // and rotate the valid entries by one toward the head while listing.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      cell_d[i] = cell_q[i];
      if (op_i == OP_EXEC && do_ins) begin
        if (PosW'(i) == ins_pos_w) begin
          cell_d[i] = req_q.value_in;
        end else if (PosW'(i) > ins_pos_w && i > 0) begin
          cell_d[i] = cell_q[i-1];
        end
      end else if (op_i == OP_EXEC && do_del) begin
        if (PosW'(i) >= pos_w && i < CAPACITY - 1) begin
          cell_d[i] = cell_q[i+1];
        end
      end else if (op_i == OP_ROTATE) begin
        if (PosW'(i) == tail_w) begin
          cell_d[i] = cell_q[0];
        end else if (PosW'(i) < tail_w && i < CAPACITY - 1) begin
          cell_d[i] = cell_q[i+1];
        end
      end
    end
  end

  // Count, list index and result register updates.
  always_comb begin
    count_d = count_q;
    idx_d   = idx_q;
    out_d   = out_q;
    case (op_i)
      OP_CAPTURE: begin
        idx_d = '0;
      end
      OP_EXEC: begin
        if (do_ins) begin
          count_d = count_q + CntW'(1);
        end else if (do_del) begin
          count_d = count_q - CntW'(1);
        end
        out_d.status      = exec_status;
        out_d.value_out   = do_del ? removed : '0;
        out_d.entry_count = CntOutW'(PosW'(count_d));
        out_d.last        = 1'b1;
      end
      OP_ROTATE: begin
        idx_d = idx_q + CntW'(1);
        if (emit) begin
          out_d.status      = ST_OK;
          out_d.value_out   = cell_q[0];
          out_d.entry_count = CntOutW'(count_w);
          out_d.last        = last_beat;
        end
      end
      default: begin
        idx_d = idx_q;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      idx_q   <= '0;
    end else begin
      count_q <= count_d;
      idx_q   <= idx_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    cell_q <= cell_d;
    out_q  <= out_d;
    if (op_i == OP_CAPTURE) begin
      req_q <= in_data_i;
    end
  end

  assign stat_o.list_multi = (req_q.req_type == REQ_LIST) && (count_q != '0);
  assign stat_o.emit       = emit;
  assign stat_o.rot_done   = ((idx_w + PosW'(1)) == count_w);
  assign out_data_o        = out_q;

endmodule

// ----- src/pls_ctrl.sv -----
// Controller of the positional list store: request sequencing state machine
// and the valid flag of the result register.
// Depends on pls_pkg.
module pls_ctrl
  import pls_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  input  pls_stat_t stat_i,
  output pls_op_e   op_o
);

  pls_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free, load;

  // The result register can take a new beat when empty or being drained.
  assign out_free = !out_valid_q || !out_stall_i;

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    op_o       = OP_NONE;
    in_stall_o = 1'b1;
    load       = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          op_o    = OP_CAPTURE;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat_i.list_multi) begin
          state_d = S_LIST;
        end else if (out_free) begin
          op_o    = OP_EXEC;
          load    = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_LIST: begin
        if (!stat_i.emit || out_free) begin
          op_o = OP_ROTATE;
          load = stat_i.emit;
          if (stat_i.rot_done) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Result valid: set on a load, cleared when the beat is taken.
  always_comb begin
    if (load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- src/positional_list_store.sv -----
// Top level of the positional list store: joins the controller and the
// datapath. Depends on pls_pkg, pls_ctrl and pls_dpath.
//
//   channel  direction  handshake               beat
//   in       input      in_valid_i/in_stall_o   pls_in_t  (request)
//   out      output     out_valid_o/out_stall_i pls_out_t (result)
//
// Insert, append and delete first capture the request, then shift the cells
// and load the result register once it is free.
// A list request streams up to MaxResults head cells while the cells rotate
// one place per cycle, held while a beat waits for the result register.
// Reset clears the count and the state; entry cells are not reset.
// A stalled result holds in the output register; the next request is taken
// meanwhile, and its result waits until the register frees up.
module positional_list_store
  import pls_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  pls_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output pls_out_t out_data_o
);

  pls_op_e   op;
  pls_stat_t stat;

  pls_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .op_o        (op)
  );

  pls_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_i       (op),
    .in_data_i  (in_data_i),
    .stat_o     (stat),
    .out_data_o (out_data_o)
  );

`ifndef ASSERT_OFF
  // The block is busy in the cycle after it takes a request.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request taken while a previous one is in progress");

  // Only the final beat of a request may carry an error.
  a_error_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != ST_OK |-> out_data_o.last)
    else $error("error status on a non-final result beat");

  // An error result carries a zero value.
  a_error_zero_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != ST_OK |-> out_data_o.value_out == '0)
    else $error("error result with a nonzero value");
`endif

endmodule
